// File: hw/rtl/lfdr_pkg.sv
// Shared types and constants for the panel frame buffer refresh unit.
package lfdr_pkg;

   localparam int PANEL_WIDTH_DEF = 84;
   localparam int PANEL_BANKS_DEF = 6;

   localparam logic [7:0] CMD_COLUMN = 8'h80;
   localparam logic [7:0] CMD_BANK   = 8'h40;

   typedef enum logic [1:0] {
      MODE_PIXEL = 2'd0,
      MODE_SCAN  = 2'd1,
      MODE_CLEAR = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      S_INIT,
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_data;
      logic       last;
      logic       frame_done;
   } result_type;

endpackage

// File: hw/rtl/lfdr_byte_ram.sv
// Single write port, single read port byte memory with registered read data.
module lfdr_byte_ram #(
   parameter int DEPTH = 504,
   parameter int AW    = 9
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/lcd_frame_dirty_refresh_unit.sv
// Top level of the panel frame buffer with dirty byte refresh scan.
// A pixel write or scan step is a memory read on acceptance in idle, then modify and write back
// in the execute state; scan results are registered into the result buffer and offered from there.
// A new item is accepted only in idle, once the previous one is finished, since the stores have
// a registered read; a scan step waits in execute until the result buffer holds at most one beat
// being taken. Clear mode sweeps the frame store one byte a cycle.
// Reset: both stores are swept to zero, req_ready low meanwhile.
module lcd_frame_dirty_refresh_unit
   import lfdr_pkg::*;
#(
   parameter int PANEL_WIDTH = PANEL_WIDTH_DEF,
   parameter int PANEL_BANKS = PANEL_BANKS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_mode,
   input  logic [7:0] req_x_coord,
   input  logic [7:0] req_y_coord,
   input  logic       req_pixel_value,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_data,
   output logic       rsp_last,
   output logic       rsp_frame_done
);

   localparam int DEPTH = PANEL_WIDTH * PANEL_BANKS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(PANEL_WIDTH);
   localparam int BW    = (PANEL_BANKS > 1) ? $clog2(PANEL_BANKS) : 1;
   localparam int ROWS  = 8 * PANEL_BANKS;

   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] LAST_COL  = CW'(PANEL_WIDTH - 1);
   localparam logic [7:0]    LAST_X    = 8'(PANEL_WIDTH - 1);
   localparam logic [7:0]    LAST_Y    = 8'(ROWS - 1);

   // Control state.
   state_type       state_ff, state_in;
   logic [AW-1:0]   clr_ff, clr_in;
   logic [AW-1:0]   scan_index_ff, scan_index_in;
   logic [CW-1:0]   scan_column_ff, scan_column_in;
   logic [BW-1:0]   scan_bank_ff, scan_bank_in;
   logic            skipped_ff, skipped_in;
   logic [1:0]      res_cnt_ff, res_cnt_in;

   // Captured item payload.
   logic [1:0]      mode_ff, mode_in;
   logic [AW-1:0]   addr_ff, addr_in;
   logic [2:0]      ybit_ff, ybit_in;
   logic            pixel_ff, pixel_in;

   // Result buffer; entry zero drives the result port.
   result_type      res_ff [3];
   result_type      res_in [3];

   // Memory ports.
   logic            frame_we, shadow_we, rd_en;
   logic [AW-1:0]   frame_waddr, shadow_waddr, rd_addr;
   logic [7:0]      frame_wdata, shadow_wdata;
   logic [7:0]      frame_q, shadow_q;

   // Pixel address, with both coordinates clamped to the panel edge.
   logic [7:0]      x_clamp, y_clamp;
   logic [BW-1:0]   pix_bank;
   logic [AW-1:0]   pix_addr;

   // Scan step decisions.
   logic            at_start, final_byte, changed, resend;
   logic            can_load, rsp_pop;
   result_type      built [3];
   logic [1:0]      built_cnt;
   logic [7:0]      col_cmd, bank_cmd;

   lfdr_byte_ram #(.DEPTH(DEPTH), .AW(AW)) u_frame_ram (
      .clock   (clock),
      .wr_en   (frame_we),
      .wr_addr (frame_waddr),
      .wr_data (frame_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (frame_q)
   );

   lfdr_byte_ram #(.DEPTH(DEPTH), .AW(AW)) u_shadow_ram (
      .clock   (clock),
      .wr_en   (shadow_we),
      .wr_addr (shadow_waddr),
      .wr_data (shadow_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (shadow_q)
   );

   always_comb begin
      x_clamp  = (req_x_coord > LAST_X) ? LAST_X : req_x_coord;
      y_clamp  = (req_y_coord > LAST_Y) ? LAST_Y : req_y_coord;
      pix_bank = BW'(y_clamp >> 3);
      pix_addr = AW'(x_clamp) + AW'(32'(pix_bank) * PANEL_WIDTH);
   end

   assign rsp_valid      = (res_cnt_ff != 2'd0);
   assign rsp_out_byte   = res_ff[0].out_byte;
   assign rsp_is_data    = res_ff[0].is_data;
   assign rsp_last       = res_ff[0].last;
   assign rsp_frame_done = res_ff[0].frame_done;
   assign rsp_pop        = rsp_valid && rsp_ready;
   assign req_ready      = (state_ff == S_IDLE);

   // The buffer may take a new step's results once it drains this cycle.
   assign can_load = (res_cnt_ff == 2'd0) || ((res_cnt_ff == 2'd1) && rsp_ready);

   // Build the beats of one scan step from the stored bytes just read.
   always_comb begin
      at_start   = (scan_index_ff == '0);
      final_byte = (scan_index_ff == LAST_ADDR);
      changed    = (frame_q != shadow_q);
      resend     = changed && skipped_ff && !at_start;
      col_cmd    = CMD_COLUMN | {1'b0, 7'(scan_column_ff)};
      bank_cmd   = CMD_BANK | {5'b00000, 3'(scan_bank_ff)};
      for (int k = 0; k < 3; k++) begin
         built[k] = '{out_byte: frame_q, is_data: 1'b1, last: 1'b0,
                      frame_done: final_byte};
      end
      built_cnt = 2'd0;
      if (at_start) begin
         built[0].out_byte = CMD_COLUMN;
         built[0].is_data  = 1'b0;
         built[1].out_byte = CMD_BANK;
         built[1].is_data  = 1'b0;
         built_cnt         = changed ? 2'd3 : 2'd2;
      end else if (resend) begin
         built[0].out_byte = col_cmd;
         built[0].is_data  = 1'b0;
         built[1].out_byte = bank_cmd;
         built[1].is_data  = 1'b0;
         built_cnt         = 2'd3;
      end else if (changed) begin
         built_cnt = 2'd1;
      end
      for (int k = 0; k < 3; k++) begin
         built[k].last = (2'(k + 1) == built_cnt);
      end
   end

   always_comb begin
      state_in       = state_ff;
      clr_in         = clr_ff;
      scan_index_in  = scan_index_ff;
      scan_column_in = scan_column_ff;
      scan_bank_in   = scan_bank_ff;
      skipped_in     = skipped_ff;
      mode_in        = mode_ff;
      addr_in        = addr_ff;
      ybit_in        = ybit_ff;
      pixel_in       = pixel_ff;
      frame_we       = 1'b0;
      frame_waddr    = clr_ff;
      frame_wdata    = 8'h00;
      shadow_we      = 1'b0;
      shadow_waddr   = clr_ff;
      shadow_wdata   = 8'h00;
      rd_en          = 1'b0;
      rd_addr        = pix_addr;
      res_cnt_in     = res_cnt_ff;
      res_in         = res_ff;

      // Drain one beat per accepted result.
      if (rsp_pop) begin
         res_in[0]  = res_ff[1];
         res_in[1]  = res_ff[2];
         res_cnt_in = res_cnt_ff - 2'd1;
      end

      unique case (state_ff)
         S_INIT, S_CLEAR: begin
            // Sweep: the reset sweep zeroes both stores, clear mode only the image.
            frame_we  = 1'b1;
            shadow_we = (state_ff == S_INIT);
            if (clr_ff == LAST_ADDR) begin
               clr_in   = '0;
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               rd_en    = 1'b1;
               rd_addr  = (req_mode == MODE_SCAN) ? scan_index_ff : pix_addr;
               mode_in  = req_mode;
               addr_in  = pix_addr;
               ybit_in  = y_clamp[2:0];
               pixel_in = req_pixel_value;
               if (req_mode == MODE_CLEAR) begin
                  state_in = S_CLEAR;
               end else if (req_mode == MODE_PIXEL || req_mode == MODE_SCAN) begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            if (mode_ff == MODE_PIXEL) begin
               frame_we    = 1'b1;
               frame_waddr = addr_ff;
               frame_wdata = frame_q;
               frame_wdata[ybit_ff] = pixel_ff;
               state_in    = S_IDLE;
            end else if (can_load) begin
               // A sent byte becomes what the panel shows.
               shadow_we    = changed;
               shadow_waddr = scan_index_ff;
               shadow_wdata = frame_q;
               skipped_in   = !changed;
               res_in       = built;
               res_cnt_in   = built_cnt;
               if (final_byte) begin
                  scan_index_in  = '0;
                  scan_column_in = '0;
                  scan_bank_in   = '0;
               end else begin
                  scan_index_in = scan_index_ff + 1'b1;
                  if (scan_column_ff == LAST_COL) begin
                     scan_column_in = '0;
                     scan_bank_in   = scan_bank_ff + 1'b1;
                  end else begin
                     scan_column_in = scan_column_ff + 1'b1;
                  end
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_INIT;
         clr_ff         <= '0;
         scan_index_ff  <= '0;
         scan_column_ff <= '0;
         scan_bank_ff   <= '0;
         skipped_ff     <= 1'b0;
         res_cnt_ff     <= 2'd0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         scan_index_ff  <= scan_index_in;
         scan_column_ff <= scan_column_in;
         scan_bank_ff   <= scan_bank_in;
         skipped_ff     <= skipped_in;
         res_cnt_ff     <= res_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      addr_ff  <= addr_in;
      ybit_ff  <= ybit_in;
      pixel_ff <= pixel_in;
      res_ff   <= res_in;
   end

   // A beat that is not the last of its step always has a successor buffered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> res_cnt_ff >= 2'd2)
      else $error("non-final beat without a following beat");

   // All beats of one step carry the same frame completion flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_pop && !rsp_last |=> rsp_valid && rsp_frame_done == $past(rsp_frame_done))
      else $error("frame completion flag changed within a step");

   // The scan position stays on the panel.
   assert property (@(posedge clock) disable iff (reset)
      32'(scan_column_ff) < PANEL_WIDTH && 32'(scan_bank_ff) < PANEL_BANKS)
      else $error("scan position off the panel");

   // A clear request starts the frame store sweep on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_CLEAR |=> state_ff == S_CLEAR && clr_ff == '0)
      else $error("clear request did not start the sweep");

endmodule
